FILE: src/lsc_pkg.sv
package lsc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_MUL,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } eng_state_t;

  // Bit positions inside a 4-bit outcode.
  localparam int OC_LEFT   = 0;
  localparam int OC_RIGHT  = 1;
  localparam int OC_BOTTOM = 2;
  localparam int OC_TOP    = 3;

  localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [1:0] REG_WIN_BOTTOM = 2'd1;
  localparam logic [1:0] REG_WIN_RIGHT  = 2'd2;
  localparam logic [1:0] REG_WIN_TOP    = 2'd3;

  localparam logic [2:0] MAX_STEPS = 3'd4;

endpackage

FILE: src/lsc_seg_if.sv
interface lsc_seg_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] start_x;
  logic signed [W-1:0] start_y;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

FILE: src/lsc_clip_if.sv
interface lsc_clip_if #(
  parameter int W = 16
) ();
  logic                valid;
  logic                ready;
  logic                visible;
  logic signed [W-1:0] clip_start_x;
  logic signed [W-1:0] clip_start_y;
  logic signed [W-1:0] clip_end_x;
  logic signed [W-1:0] clip_end_y;

  modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                  input ready);
  modport sink (input valid, visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                output ready);
endinterface

FILE: src/line_segment_clipper_core.sv
// Cohen-Sutherland clipper for one line segment per beat against a window
// held in four registers (left, bottom, right, top), written through
// cfg_we / cfg_index / cfg_data. The user must write them only while the
// block is idle; the block itself does not enforce it. Channel seg
// carries the two endpoints; channel clip returns one beat per segment:
// visible and the clipped endpoints (all zero when rejected). Segments
// enter a two-entry queue, so up to two beats are taken while the clipping
// engine is busy. The engine handles one segment at a time: it tests
// outcodes and, for each of up to four clip steps, runs one multiply, then
// a restoring divider that retires one quotient bit per cycle, and then
// updates one endpoint; at the end it emits the result.
// The result sits in an output register; the engine may start the next
// segment while it waits and stalls only when a second result is ready.
// Reset (rst, synchronous) empties the queue, drops any pending result and
// loads the window with left 0, bottom 0, right 399, top 399.
module line_segment_clipper_core
  import lsc_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data,
  lsc_seg_if.sink                   seg,
  lsc_clip_if.source                clip
);

  logic signed [COORD_BITS-1:0] win_left, win_bottom, win_right, win_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_bottom <= '0;
      win_right  <= COORD_BITS'(399);
      win_top    <= COORD_BITS'(399);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIN_LEFT:   win_left   <= cfg_data;
        REG_WIN_BOTTOM: win_bottom <= cfg_data;
        REG_WIN_RIGHT:  win_right  <= cfg_data;
        REG_WIN_TOP:    win_top    <= cfg_data;
        default:        win_left   <= win_left;
      endcase
    end
  end

  lsc_seg_if #(.W(COORD_BITS)) queued ();

  lsc_queue #(.W(COORD_BITS)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .seg_in  (seg),
    .seg_out (queued.source)
  );

  lsc_engine #(.W(COORD_BITS)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .win_left   (win_left),
    .win_bottom (win_bottom),
    .win_right  (win_right),
    .win_top    (win_top),
    .seg        (queued.sink),
    .clip       (clip)
  );

endmodule

FILE: src/lsc_queue.sv
module lsc_queue
  import lsc_pkg::*;
#(
  parameter int W = 16
) (
  input  logic        clk,
  input  logic        rst,
  lsc_seg_if.sink     seg_in,
  lsc_seg_if.source   seg_out
);

  logic [4*W-1:0] mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;
  logic [4*W-1:0] head;

  assign seg_in.ready  = (count != 2'd2);
  assign seg_out.valid = (count != 2'd0);
  assign push = seg_in.valid && seg_in.ready;
  assign pop  = seg_out.valid && seg_out.ready;

  assign head = mem[rd_ptr];
  assign seg_out.start_x = head[4*W-1:3*W];
  assign seg_out.start_y = head[3*W-1:2*W];
  assign seg_out.end_x   = head[2*W-1:W];
  assign seg_out.end_y   = head[W-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= {seg_in.start_x, seg_in.start_y, seg_in.end_x, seg_in.end_y};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/lsc_engine.sv
module lsc_engine
  import lsc_pkg::*;
#(
  parameter int W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [W-1:0] win_left,
  input  logic signed [W-1:0] win_bottom,
  input  logic signed [W-1:0] win_right,
  input  logic signed [W-1:0] win_top,
  lsc_seg_if.sink             seg,
  lsc_clip_if.source          clip
);

  localparam int P  = 2 * W + 2;
  localparam int CW = $clog2(W + 2);

  eng_state_t state, state_next;

  logic signed [W-1:0] x0, y0, x1, y1;
  logic [2:0]          step;
  logic                neg;
  logic [W:0]          ma, mn, md;
  logic signed [W-1:0] a0;
  logic signed [W-1:0] bound;
  logic                sel_end;
  logic                clip_y;
  logic [W:0]          rem;
  logic [W:0]          dlo;
  logic [W:0]          quot;
  logic [CW-1:0]       dcnt;
  logic                seg_vis;

  logic                out_valid;
  logic                out_vis;
  logic signed [W-1:0] out_sx, out_sy, out_ex, out_ey;
  logic                out_free;

  logic [3:0] c0, c1, c;
  logic       trivial_accept, finish;
  logic signed [W-1:0] pa0, pa1, pb0, pb1, pbound;
  logic signed [W:0]   da, nb, db;
  logic [P-1:0]        prod;
  logic [W+1:0]        rem_sh;
  logic                qbit;
  logic [W:0]          qv;
  logic signed [W+1:0] newv;

  assign out_free = !out_valid || clip.ready;

  always_comb begin
    c0 = '0;
    c1 = '0;
    c0[OC_LEFT]   = x0 < win_left;
    c0[OC_RIGHT]  = x0 > win_right;
    c0[OC_BOTTOM] = y0 < win_bottom;
    c0[OC_TOP]    = y0 > win_top;
    c1[OC_LEFT]   = x1 < win_left;
    c1[OC_RIGHT]  = x1 > win_right;
    c1[OC_BOTTOM] = y1 < win_bottom;
    c1[OC_TOP]    = y1 > win_top;
    trivial_accept = (c0 | c1) == 4'd0;
    finish = trivial_accept || ((c0 & c1) != 4'd0) || (step == MAX_STEPS);
    c = (c0 != 4'd0) ? c0 : c1;
  end

  // Pick the boundary: top, bottom, right, left in that order.
  always_comb begin
    if (c[OC_TOP] || c[OC_BOTTOM]) begin
      pa0 = x0; pa1 = x1; pb0 = y0; pb1 = y1;
      pbound = c[OC_TOP] ? win_top : win_bottom;
    end else begin
      pa0 = y0; pa1 = y1; pb0 = x0; pb1 = x1;
      pbound = c[OC_RIGHT] ? win_right : win_left;
    end
    da = {pa1[W-1], pa1} - {pa0[W-1], pa0};
    nb = {pbound[W-1], pbound} - {pb0[W-1], pb0};
    db = {pb1[W-1], pb1} - {pb0[W-1], pb0};
  end

  always_comb begin
    prod   = {{(W+1){1'b0}}, ma} * {{(W+1){1'b0}}, mn};
    rem_sh = {rem, dlo[W]};
    qbit   = rem_sh >= {1'b0, md};
    qv     = (md == '0) ? '0 : quot;
    newv   = neg ? ({{2{a0[W-1]}}, a0} - {1'b0, qv}) : ({{2{a0[W-1]}}, a0} + {1'b0, qv});
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (seg.valid) state_next = ST_CODE;
      ST_CODE: state_next = finish ? ST_OUT : ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (dcnt == CW'(W)) state_next = ST_UPD;
      ST_UPD:  state_next = ST_CODE;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    seg.ready         = (state == ST_IDLE);
    clip.valid        = out_valid;
    clip.visible      = out_vis;
    clip.clip_start_x = out_sx;
    clip.clip_start_y = out_sy;
    clip.clip_end_x   = out_ex;
    clip.clip_end_y   = out_ey;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (clip.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x0   <= seg.start_x;
        y0   <= seg.start_y;
        x1   <= seg.end_x;
        y1   <= seg.end_y;
        step <= 3'd0;
      end
      ST_CODE: begin
        seg_vis <= trivial_accept;
        neg     <= da[W] ^ nb[W] ^ db[W];
        ma      <= da[W] ? (W+1)'(-da) : (W+1)'(da);
        mn      <= nb[W] ? (W+1)'(-nb) : (W+1)'(nb);
        md      <= db[W] ? (W+1)'(-db) : (W+1)'(db);
        a0      <= pa0;
        bound   <= pbound;
        sel_end <= (c0 == 4'd0);
        clip_y  <= c[OC_TOP] || c[OC_BOTTOM];
      end
      ST_MUL: begin
        // The quotient fits W+1 bits, so the upper half is already below the divisor.
        rem  <= prod[P-1:W+1];
        dlo  <= prod[W:0];
        quot <= '0;
        dcnt <= '0;
      end
      ST_DIV: begin
        rem  <= qbit ? (W+1)'(rem_sh - {1'b0, md}) : rem_sh[W:0];
        dlo  <= {dlo[W-1:0], 1'b0};
        quot <= {quot[W-1:0], qbit};
        dcnt <= dcnt + CW'(1);
      end
      ST_UPD: begin
        step <= step + 3'd1;
        if (sel_end) begin
          x1 <= clip_y ? newv[W-1:0] : bound;
          y1 <= clip_y ? bound : newv[W-1:0];
        end else begin
          x0 <= clip_y ? newv[W-1:0] : bound;
          y0 <= clip_y ? bound : newv[W-1:0];
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_vis <= seg_vis;
          out_sx  <= seg_vis ? x0 : '0;
          out_sy  <= seg_vis ? y0 : '0;
          out_ex  <= seg_vis ? x1 : '0;
          out_ey  <= seg_vis ? y1 : '0;
        end
      end
      default: begin
        step <= step;
      end
    endcase
  end

endmodule

FILE: dv/tb_line_segment_clipper_core.sv
`timescale 1ns / 1ps

module tb_line_segment_clipper_core;
  import lsc_pkg::*;

  localparam int CW = 16;
  localparam int SEG_PER_PHASE = 260;
  localparam int HOLD_CYCLES = 600;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey;
  } segment_t;

  typedef struct {
    logic                 vis;
    logic signed [CW-1:0] x0, y0, x1, y1;
  } clipped_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CW-1:0] cfg_data;

  lsc_seg_if #(.W(CW)) seg_ch ();
  lsc_clip_if #(.W(CW)) clip_ch ();

  line_segment_clipper_core #(.COORD_BITS(CW)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seg       (seg_ch),
    .clip      (clip_ch)
  );

  // Window as the block should hold it.
  longint win_l, win_b, win_r, win_t;

  segment_t pending_segs[$];
  clipped_t expected_clips[$];
  segment_t offered;
  int send_idle_pct, recv_stall_pct;
  bit hold_req, hold_off;
  int errors, n_visible, n_rejected, n_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] region(longint x, longint y);
    logic [3:0] c;
    c = '0;
    c[OC_LEFT]   = x < win_l;
    c[OC_RIGHT]  = x > win_r;
    c[OC_BOTTOM] = y < win_b;
    c[OC_TOP]    = y > win_t;
    return c;
  endfunction

  // SystemVerilog signed division truncates toward zero, as the block must.
  function automatic longint cross_at(longint a0, longint a1, longint b0, longint b1,
                                      longint bound);
    longint db;
    db = b1 - b0;
    if (db == 0) return a0;
    return a0 + ((a1 - a0) * (bound - b0)) / db;
  endfunction

  function automatic clipped_t clip_segment(segment_t s);
    clipped_t r;
    longint x0, y0, x1, y1, nx, ny;
    logic [3:0] c0, c1, c;
    x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
    r.vis = 1'b0;
    for (int step = 0; step <= 4; step++) begin
      c0 = region(x0, y0);
      c1 = region(x1, y1);
      if ((c0 | c1) == 0) begin
        r.vis = 1'b1;
        break;
      end
      if ((c0 & c1) != 0 || step == 4) break;
      c = (c0 != 0) ? c0 : c1;
      if (c[OC_TOP]) begin
        nx = cross_at(x0, x1, y0, y1, win_t); ny = win_t;
      end else if (c[OC_BOTTOM]) begin
        nx = cross_at(x0, x1, y0, y1, win_b); ny = win_b;
      end else if (c[OC_RIGHT]) begin
        ny = cross_at(y0, y1, x0, x1, win_r); nx = win_r;
      end else begin
        ny = cross_at(y0, y1, x0, x1, win_l); nx = win_l;
      end
      if (c0 != 0) begin
        x0 = nx; y0 = ny;
      end else begin
        x1 = nx; y1 = ny;
      end
    end
    if (r.vis) begin
      r.x0 = x0[CW-1:0]; r.y0 = y0[CW-1:0]; r.x1 = x1[CW-1:0]; r.y1 = y1[CW-1:0];
    end else begin
      r.x0 = '0; r.y0 = '0; r.x1 = '0; r.y1 = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Driver: a new beat is picked only when the current one is gone.
  always @(posedge clk) begin
    if (rst) begin
      seg_ch.valid <= 1'b0;
    end else begin
      if (seg_ch.valid && seg_ch.ready) begin
        expected_clips.push_back(clip_segment(offered));
        n_sent++;
      end
      if (!seg_ch.valid || seg_ch.ready) begin
        if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_segs.pop_front();
          seg_ch.valid   <= 1'b1;
          seg_ch.start_x <= offered.sx;
          seg_ch.start_y <= offered.sy;
          seg_ch.end_x   <= offered.ex;
          seg_ch.end_y   <= offered.ey;
        end else begin
          seg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    clipped_t want;
    if (rst) begin
      clip_ch.ready <= 1'b0;
    end else begin
      if (clip_ch.valid && clip_ch.ready) begin
        if (expected_clips.size() == 0) begin
          $display("result beat with nothing expected at %0t", $realtime);
          errors++;
        end else begin
          want = expected_clips.pop_front();
          if (clip_ch.visible !== want.vis) report_mismatch("visible", clip_ch.visible, want.vis);
          if (clip_ch.clip_start_x !== want.x0)
            report_mismatch("clip_start_x", clip_ch.clip_start_x, want.x0);
          if (clip_ch.clip_start_y !== want.y0)
            report_mismatch("clip_start_y", clip_ch.clip_start_y, want.y0);
          if (clip_ch.clip_end_x !== want.x1)
            report_mismatch("clip_end_x", clip_ch.clip_end_x, want.x1);
          if (clip_ch.clip_end_y !== want.y1)
            report_mismatch("clip_end_y", clip_ch.clip_end_y, want.y1);
          if (want.vis) n_visible++;
          else n_rejected++;
        end
      end
      clip_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the input queue fills and back-pressures.
  initial begin
    hold_off = 1'b0;
    forever begin
      wait (hold_req);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off = 1'b0;
      hold_req = 1'b0;
    end
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, longint val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIN_LEFT:   win_l = val;
      REG_WIN_BOTTOM: win_b = val;
      REG_WIN_RIGHT:  win_r = val;
      default:        win_t = val;
    endcase
  endtask

  task automatic set_window(longint l, longint b, longint r, longint t);
    write_reg(REG_WIN_LEFT, l);
    write_reg(REG_WIN_BOTTOM, b);
    write_reg(REG_WIN_RIGHT, r);
    write_reg(REG_WIN_TOP, t);
  endtask

  task automatic add_seg(longint sx, longint sy, longint ex, longint ey);
    segment_t s;
    s.sx = sx[CW-1:0]; s.sy = sy[CW-1:0]; s.ex = ex[CW-1:0]; s.ey = ey[CW-1:0];
    pending_segs.push_back(s);
  endtask

  // Mostly near the window, some anywhere, some on edges and limits.
  function automatic longint pick_coord(longint lo, longint hi);
    longint a, b, span, v;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a + 8;
    case ($urandom_range(7))
      0, 1: v = $signed(16'($urandom));
      2: begin
        case ($urandom_range(5))
          0: v = lo;
          1: v = hi;
          2: v = lo - 1;
          3: v = hi + 1;
          4: v = -32768;
          default: v = 32767;
        endcase
      end
      default: v = a - span + longint'($urandom_range(3 * span));
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  task automatic wait_drained();
    wait (pending_segs.size() == 0 && !seg_ch.valid && expected_clips.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    longint windows[6][4];
    windows = '{'{-100, -50, 100, 50},
                '{-32768, -32768, 32767, 32767},
                '{100, 100, -100, -100},
                '{5, 5, 5, 5},
                '{-32768, 0, 0, 32767},
                '{-300, -2000, 2500, 700}};
    errors = 0; n_visible = 0; n_rejected = 0; n_sent = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_req = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = REG_WIN_LEFT; cfg_data = '0;
    seg_ch.valid = 1'b0;
    seg_ch.start_x = '0; seg_ch.start_y = '0; seg_ch.end_x = '0; seg_ch.end_y = '0;
    clip_ch.ready = 1'b0;
    win_l = 0; win_b = 0; win_r = 399; win_t = 399;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed cases against the reset window.
    add_seg(10, 10, 300, 300);
    add_seg(0, 0, 399, 399);
    add_seg(-50, 10, -5, 300);
    add_seg(-50, 500, 600, 450);
    add_seg(-100, 200, 500, 200);
    add_seg(200, -100, 200, 500);
    add_seg(-32768, -32768, 32767, 32767);
    add_seg(32767, -32768, -32768, 32767);
    add_seg(-1000, 150, 150, 1200);
    add_seg(-10, 350, 420, -20);
    add_seg(-200, 100, 100, -200);
    add_seg(500, 500, 500, 500);
    add_seg(200, 200, 200, 200);
    add_seg(-1, -1, 400, 400);
    add_seg(399, 0, 400, 0);
    add_seg(-32768, 32767, 32767, -32768);
    add_seg(600, -100, -100, 600);
    add_seg(-300, 450, 700, -60);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      set_window(windows[ph][0], windows[ph][1], windows[ph][2], windows[ph][3]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 59; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 59; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int i = 0; i < SEG_PER_PHASE; i++)
        add_seg(pick_coord(win_l, win_r), pick_coord(win_b, win_t),
                pick_coord(win_l, win_r), pick_coord(win_b, win_t));
      if (ph == 0) hold_req = 1'b1;
      wait_drained();
    end

    $display("%0d segments clipped over 7 window settings, including inverted and extreme",
             n_sent);
    $display("results: %0d visible, %0d rejected; mismatches: %0d",
             n_visible, n_rejected, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lsc_pkg.sv
src/lsc_seg_if.sv
src/lsc_clip_if.sv
src/lsc_queue.sv
src/lsc_engine.sv
src/line_segment_clipper_core.sv
dv/tb_line_segment_clipper_core.sv
